@@ src/citp_pkg.sv @@
package citp_pkg;

	localparam int StringChars = 20;
	localparam int CharW = $clog2(StringChars + 1);

	typedef enum logic [4:0] {
		PH_TAG, PH_LEN, PH_SKIP, PH_REV, PH_STR, PH_MANF, PH_FUNC, PH_CFG,
		PH_INDEX, PH_IFACE, PH_FEAT, PH_PWRSEL, PH_PARAM, PH_TIMING, PH_IO,
		PH_RANGE, PH_ADDR, PH_IOLEN, PH_SKIPN, PH_IRQ, PH_IRQMASK, PH_MEM,
		PH_MISC, PH_SUBCODE, PH_SUBLEN, PH_SUBBODY
	} phase_t;

	localparam logic [4:0] K_REV = 5'd0;
	localparam logic [4:0] K_STR = 5'd1;
	localparam logic [4:0] K_MANF = 5'd5;
	localparam logic [4:0] K_CARD = 5'd6;
	localparam logic [4:0] K_FTYPE = 5'd7;
	localparam logic [4:0] K_FSYS = 5'd8;
	localparam logic [4:0] K_CFG = 5'd9;
	localparam logic [4:0] K_INDEX = 5'd10;
	localparam logic [4:0] K_IOADDR = 5'd11;
	localparam logic [4:0] K_IOLEN = 5'd12;
	localparam logic [4:0] K_IRQ = 5'd13;
	localparam logic [4:0] K_IRQMASK = 5'd14;
	localparam logic [4:0] K_FLAGS = 5'd15;
	localparam logic [4:0] K_END = 5'd16;

	localparam logic [7:0] TAG_END = 8'h14;
	localparam logic [7:0] TAG_NULL = 8'hFF;
	localparam logic [7:0] TAG_VERS1 = 8'h15;
	localparam logic [7:0] TAG_CONFIG = 8'h1A;
	localparam logic [7:0] TAG_CFTABLE = 8'h1B;
	localparam logic [7:0] TAG_MANFID = 8'h20;
	localparam logic [7:0] TAG_FUNCID = 8'h21;
	localparam logic [7:0] SUB_HOST = 8'hC0;
	localparam logic [7:0] SUB_MODULE = 8'hC1;

	typedef struct packed {
		logic [4:0]  kind;
		logic [31:0] value;
		logic [3:0]  entry_number;
	} result_t;

	function automatic logic [2:0] size_of(input logic [1:0] c);
		case (c)
			2'd0: size_of = 3'd0;
			2'd1: size_of = 3'd1;
			2'd2: size_of = 3'd2;
			default: size_of = 3'd4;
		endcase
	endfunction

	function automatic logic [7:0] host_char(input logic [3:0] i);
		case (i)
			4'd0: host_char = "D";
			4'd1: host_char = "V";
			4'd2: host_char = "B";
			4'd3: host_char = "_";
			4'd4: host_char = "H";
			4'd5: host_char = "O";
			4'd6: host_char = "S";
			default: host_char = "T";
		endcase
	endfunction

	function automatic logic [7:0] module_char(input logic [3:0] i);
		case (i)
			4'd0: module_char = "D";
			4'd1: module_char = "V";
			4'd2: module_char = "B";
			4'd3: module_char = "_";
			4'd4: module_char = "C";
			4'd5: module_char = "I";
			4'd6: module_char = "_";
			4'd7: module_char = "M";
			4'd8: module_char = "O";
			4'd9: module_char = "D";
			4'd10: module_char = "U";
			4'd11: module_char = "L";
			default: module_char = "E";
		endcase
	endfunction

endpackage

@@ src/citp_out_queue.sv @@
module citp_out_queue import citp_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  logic [1:0]     load_count,
	input  result_t        load_res [3],
	output logic           busy,
	output logic           out_valid,
	input  logic           out_ready,
	output result_t        out_res,
	output logic           out_last
);
	result_t     buf_q [3];
	logic [1:0]  cnt_q;
	logic [1:0]  rd_q;
	logic        take;

	assign out_valid = cnt_q != 2'd0;
	assign take = out_valid && out_ready;
	assign out_res = buf_q[rd_q];
	assign out_last = cnt_q == 2'd1;
	// can take new results when empty or when the one left is leaving
	assign busy = cnt_q > 2'd1 || (cnt_q == 2'd1 && !out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q <= 2'd0;
		end else if (load) begin
			cnt_q <= load_count;
			rd_q <= 2'd0;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
			rd_q <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= load_res;
		end
	end
endmodule

@@ src/card_info_tuple_parser_core.sv @@
// channel  dir  handshake                payload
// in       in   in_valid / in_ready      data_byte, start_req
// out      out  out_valid / out_ready    kind, value, entry_number, last
// cfg      in   cfg_valid / cfg_ready    cfg_data (body_byte_limit)
// One byte per cycle while in_ready is high: the parse state updates in the accepting cycle and its
// results (up to 3) go to a result buffer, one beat per cycle while out_ready is high.
// A byte causing several results blocks the input while they drain.
// Reset: parse state clear, limit 336. start_req clears parse state only.
// in_ready drops while the buffer holds more than its last beat, or its last beat with out_ready low.
module card_info_tuple_parser_core import citp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        start_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  kind,
	output logic [31:0] value,
	output logic [3:0]  entry_number,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data
);
	phase_t      phase_q, ph;
	logic [7:0]  code_q, code;
	logic [7:0]  len_q, len;
	logic [7:0]  pos_q, pos;
	logic [9:0]  total_q, total;
	logic [31:0] acc_q, acc;
	logic [2:0]  left_q, left;
	logic [1:0]  strn_q, strn;
	logic [CharW-1:0] chars_q, chars;
	logic [3:0]  entry_q, entry;
	logic [7:0]  ff_q, ff;
	logic [6:0]  psel_q, psel;
	logic [3:0]  rsz_q, rsz;
	logic [7:0]  scode_q, scode;
	logic [7:0]  sleft_q, sleft;
	logic [3:0]  midx_q, midx;
	logic        malive_q, malive;
	logic [1:0]  tflags_q, tflags;
	logic        fin_q, fin;
	logic [9:0]  limit_q;

	result_t     res [3];
	logic [1:0]  n;
	logic        busy, accept;
	result_t     ores;
	logic [7:0]  b;

	assign b = data_byte;
	assign in_ready = !busy;
	assign accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 10'd336;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	function automatic void emit(inout result_t r [3], inout logic [1:0] k,
		input logic [4:0] kd, input logic [31:0] v, input logic [3:0] e);
		if (k != 2'd3) begin
			r[k].kind = kd;
			r[k].value = v;
			r[k].entry_number = (kd >= K_INDEX && kd <= K_FLAGS) ? e : 4'd0;
			k = k + 2'd1;
		end
	endfunction

	always_comb begin
		logic [7:0] p1;
		logic [10:0] t;
		logic [2:0] as_s, ls_s, sz;
		logic [1:0] kk;
		logic [3:0] nw;
		logic [2:0] cs, hs;
		logic [7:0] mch;
		logic       nd, adv;
		logic [2:0] tm;
		ph = phase_q; code = code_q; len = len_q; pos = pos_q; total = total_q;
		acc = acc_q; left = left_q; strn = strn_q; chars = chars_q;
		entry = entry_q; ff = ff_q; psel = psel_q; rsz = rsz_q; scode = scode_q;
		sleft = sleft_q; midx = midx_q; malive = malive_q; tflags = tflags_q;
		fin = fin_q;
		for (int i = 0; i < 3; i++) res[i] = '0;
		n = 2'd0;
		nd = 1'b0; adv = 1'b0;
		p1 = '0; t = '0; as_s = '0; ls_s = '0; sz = '0; kk = '0; nw = '0;
		cs = '0; hs = '0; mch = '0; tm = '0;
		if (start_req) begin
			ph = PH_TAG; code = '0; len = '0; pos = '0; total = '0; acc = '0;
			left = '0; strn = '0; chars = '0; entry = '0; ff = '0; psel = '0;
			rsz = '0; scode = '0; sleft = '0; midx = '0; malive = 1'b1;
			tflags = '0; fin = 1'b0;
		end
		if (!fin) begin
			if (ph == PH_TAG) begin
				if (b == TAG_END || b == TAG_NULL) begin
					emit(res, n, K_END, 32'd0, entry);
					fin = 1'b1;
				end else begin
					code = b;
					ph = PH_LEN;
				end
			end else if (ph == PH_LEN) begin
				t = {1'b0, total} + {3'b0, b};
				total = (t > 11'd1023) ? 10'd1023 : t[9:0];
				len = b; pos = '0; acc = '0;
				case (code)
					TAG_VERS1: begin ph = PH_REV; strn = '0; chars = '0; end
					TAG_MANFID: ph = PH_MANF;
					TAG_FUNCID: ph = PH_FUNC;
					TAG_CONFIG: ph = PH_CFG;
					TAG_CFTABLE: begin ph = PH_INDEX; tflags = '0; ff = '0; end
					default: ph = PH_SKIP;
				endcase
				adv = b == 8'd0;
			end else begin
				case (ph)
					PH_REV: begin
						acc = {16'd0, acc[7:0], b};
						if (pos == 8'd1) begin
							emit(res, n, K_REV, acc, entry);
							ph = PH_STR;
						end
					end
					PH_STR: begin
						if (b == 8'hFF) ph = PH_SKIP;
						else if (b == 8'd0) begin
							if (strn == 2'd3) ph = PH_SKIP;
							else begin strn = strn + 2'd1; chars = '0; end
						end else if (chars < CharW'(StringChars)) begin
							emit(res, n, K_STR + {3'd0, strn}, {24'd0, b}, entry);
							chars = chars + 1'b1;
						end
					end
					PH_MANF: begin
						acc = {16'd0, acc[7:0], b};
						if (pos == 8'd1) emit(res, n, K_MANF, acc, entry);
						if (pos == 8'd3) begin
							emit(res, n, K_CARD, acc, entry);
							ph = PH_SKIP;
						end
					end
					PH_FUNC: begin
						if (pos == 8'd0) emit(res, n, K_FTYPE, {24'd0, b}, entry);
						else begin
							emit(res, n, K_FSYS, {24'd0, b}, entry);
							ph = PH_SKIP;
						end
					end
					PH_CFG: begin
						if (pos == 8'd0) begin
							left = (b[1:0] <= 2'd1) ? {1'b0, b[1:0]} + 3'd1 : 3'd0;
							acc = '0;
							if (left == 3'd0) ph = PH_SKIP;
						end else if (pos >= 8'd2) begin
							if (pos[0]) acc[15:8] = b;
							else acc[7:0] = b;
							if (pos == 8'd1 + {5'd0, left}) begin
								emit(res, n, K_CFG, acc, entry);
								ph = PH_SKIP;
							end
						end
					end
					PH_INDEX: begin
						emit(res, n, K_INDEX, {26'd0, b[5:0]}, entry);
						ph = b[7] ? PH_IFACE : PH_FEAT;
					end
					PH_IFACE: ph = PH_FEAT;
					PH_FEAT: begin ff = b; nd = 1'b1; end
					PH_PWRSEL: begin
						psel = b[6:0];
						if (psel != 7'd0) ph = PH_PARAM;
						else begin
							if (ff[1:0] != 2'd0) ff = ff - 8'd1;
							nd = 1'b1;
						end
					end
					PH_PARAM: begin
						if (!b[7]) begin
							psel = psel & (psel - 7'd1);
							if (psel == 7'd0) begin
								if (ff[1:0] != 2'd0) ff = ff - 8'd1;
								nd = 1'b1;
							end
						end
					end
					PH_TIMING: begin
						ff = ff & 8'hFB;
						tm = {b[7:5] != 3'd7, b[4:2] != 3'd7, b[1:0] != 2'd3};
						psel = {4'd0, tm};
						if (tm != 3'd0) ph = PH_PARAM; else nd = 1'b1;
					end
					PH_IO: begin
						ff = ff & 8'hF7;
						if (b[7]) ph = PH_RANGE; else nd = 1'b1;
					end
					PH_RANGE: begin
						as_s = size_of(b[5:4]);
						ls_s = size_of(b[7:6]);
						rsz = b[7:4];
						sleft = 8'({4'd0, b[3:0]} * ({5'd0, as_s} + {5'd0, ls_s}));
						acc = '0;
						left = as_s;
						if (as_s != 3'd0) ph = PH_ADDR;
						else begin
							left = ls_s;
							if (ls_s != 3'd0) ph = PH_IOLEN;
							else if (sleft != 8'd0) ph = PH_SKIPN;
							else nd = 1'b1;
						end
					end
					PH_ADDR, PH_IOLEN: begin
						sz = size_of(ph == PH_ADDR ? rsz[1:0] : rsz[3:2]);
						kk = 2'(sz - left);
						case (kk)
							2'd0: acc[7:0] = acc[7:0] | b;
							2'd1: acc[15:8] = acc[15:8] | b;
							2'd2: acc[23:16] = acc[23:16] | b;
							default: acc[31:24] = acc[31:24] | b;
						endcase
						left = left - 3'd1;
						if (left == 3'd0) begin
							if (ph == PH_ADDR) begin
								emit(res, n, K_IOADDR, acc, entry);
								acc = '0;
								left = size_of(rsz[3:2]);
								if (left != 3'd0) ph = PH_IOLEN;
								else if (sleft != 8'd0) ph = PH_SKIPN;
								else nd = 1'b1;
							end else begin
								emit(res, n, K_IOLEN, acc, entry);
								if (sleft != 8'd0) ph = PH_SKIPN;
								else nd = 1'b1;
							end
						end
					end
					PH_SKIPN: begin
						if (sleft != 8'd0) sleft = sleft - 8'd1;
						if (sleft == 8'd0) nd = 1'b1;
					end
					PH_IRQ: begin
						ff = ff & 8'hEF;
						emit(res, n, K_IRQ, {24'd0, b}, entry);
						if (b[4]) begin acc = '0; left = 3'd2; ph = PH_IRQMASK; end
						else nd = 1'b1;
					end
					PH_IRQMASK: begin
						if (left[0]) acc[15:8] = acc[15:8] | b;
						else acc[7:0] = acc[7:0] | b;
						left = left - 3'd1;
						if (left == 3'd0) begin
							emit(res, n, K_IRQMASK, acc, entry);
							nd = 1'b1;
						end
					end
					PH_MEM: begin
						nw = {1'b0, b[2:0]} + 4'd1;
						cs = {1'b0, b[6:5]};
						hs = b[7] ? cs : 3'd0;
						sleft = 8'(nw * ({1'b0, b[4:3]} + cs + hs));
						if (sleft != 8'd0) ph = PH_SKIPN; else nd = 1'b1;
					end
					PH_MISC: begin
						if (!b[7]) begin ff = ff & 8'h7F; nd = 1'b1; end
					end
					PH_SUBCODE: begin scode = b; ph = PH_SUBLEN; end
					PH_SUBLEN: begin
						sleft = b; midx = '0; malive = 1'b1;
						ph = (b == 8'd0) ? PH_SUBCODE : PH_SUBBODY;
					end
					PH_SUBBODY: begin
						if (malive && (scode == SUB_HOST || scode == SUB_MODULE)) begin
							if (scode == SUB_HOST) mch = host_char(midx);
							else mch = module_char(midx);
							if (midx < ((scode == SUB_HOST) ? 4'd8 : 4'd13)) begin
								if (b == mch) midx = midx + 4'd1;
								else malive = 1'b0;
							end else begin
								if (b == 8'd0) tflags = tflags |
									((scode == SUB_HOST) ? 2'b01 : 2'b10);
								malive = 1'b0;
							end
						end
						sleft = sleft - 8'd1;
						if (sleft == 8'd0) ph = PH_SUBCODE;
					end
					default: ;
				endcase
				if (nd) begin
					if (ff[1:0] != 2'd0) ph = PH_PWRSEL;
					else if (ff[2]) ph = PH_TIMING;
					else if (ff[3]) ph = PH_IO;
					else if (ff[4]) ph = PH_IRQ;
					else if (ff[6:5] != 2'd0) begin
						if (ff[6:5] == 2'd3) ph = PH_MEM;
						else begin
							sleft = (ff[6:5] == 2'd1) ? 8'd2 : 8'd4;
							ph = PH_SKIPN;
						end
						ff = ff & 8'h9F;
					end else if (ff[7]) ph = PH_MISC;
					else ph = PH_SUBCODE;
				end
				p1 = pos + 8'd1;
				pos = p1;
				adv = p1 >= len;
			end
			if (adv) begin
				if (code == TAG_CFTABLE) begin
					emit(res, n, K_FLAGS, {30'd0, tflags}, entry);
					if (entry != 4'd15) entry = entry + 4'd1;
				end
				ph = PH_TAG;
				if (total >= limit_q) begin
					emit(res, n, K_END, 32'd0, entry);
					fin = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG; code_q <= '0; len_q <= '0; pos_q <= '0;
			total_q <= '0; acc_q <= '0; left_q <= '0; strn_q <= '0;
			chars_q <= '0; entry_q <= '0; ff_q <= '0; psel_q <= '0;
			rsz_q <= '0; scode_q <= '0; sleft_q <= '0; midx_q <= '0;
			malive_q <= 1'b1; tflags_q <= '0; fin_q <= 1'b0;
		end else if (accept) begin
			phase_q <= ph; code_q <= code; len_q <= len; pos_q <= pos;
			total_q <= total; acc_q <= acc; left_q <= left; strn_q <= strn;
			chars_q <= chars; entry_q <= entry; ff_q <= ff; psel_q <= psel;
			rsz_q <= rsz; scode_q <= scode; sleft_q <= sleft; midx_q <= midx;
			malive_q <= malive; tflags_q <= tflags; fin_q <= fin;
		end
	end

	citp_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept && n != 2'd0),
		.load_count (n),
		.load_res   (res),
		.busy       (busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_res    (ores),
		.out_last   (last)
	);

	assign kind = ores.kind;
	assign value = ores.value;
	assign entry_number = ores.entry_number;
endmodule
